// ===== rtl/csvfs_pkg.sv =====
// ---------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV field splitter: character codes,
// result kinds and the command word passed from the front end to the back end.
// ---------------------------------------------------------------------------
package csvfs_pkg;

    // Default depths
    localparam int PENDING_MAX_DEF = 32;  // trailing blank buffer, 2 or more
    localparam int QUEUE_DEPTH_DEF = 4;   // command queue, 2 or more

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FIELD = 2'd1,
        KIND_ROW   = 2'd2
    } kind_t;

    // Commands from front end to back end
    typedef enum logic [1:0] {
        OP_WS    = 2'd0,  // park one blank (data[0]: 1 tab, 0 space)
        OP_CHAR  = 2'd1,  // flush parked blanks, then the byte
        OP_FIELD = 2'd2,  // end of field mark
        OP_ROW   = 2'd3   // end of row mark
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       ovf;   // sticky overflow as it stood before the step
    } cmd_t;

endpackage

// ===== rtl/csvfs_front.sv =====
// ---------------------------------------------------------------------------
// csvfs_front
// Byte classifier: quote, CR/LF and field tracking; turns each accepted
// beat into at most one command for the back end.
// ---------------------------------------------------------------------------
module csvfs_front
    import csvfs_pkg::*;
#(
    parameter int PENDING_MAX = PENDING_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       push,
    output cmd_t       cmd
);

    localparam int CW = $clog2(PENDING_MAX + 1);

    logic          inq_reg, inq_next;
    logic          qp_reg, qp_next;
    logic          acr_reg, acr_next;
    logic          fs_reg, fs_next;
    logic          rne_reg, rne_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;

    always_comb
    begin
        logic skip;
        logic cont;
        logic emit;
        logic inq_v;
        op_t  op;
        logic [7:0] data;

        skip     = 1'b0;
        cont     = 1'b0;
        emit     = 1'b0;
        op       = OP_CHAR;
        data     = in_byte;
        inq_v    = inq_reg;
        inq_next = inq_reg;
        qp_next  = qp_reg;
        acr_next = acr_reg;
        fs_next  = fs_reg;
        rne_next = rne_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;

        if (end_of_input)
        begin
            if (rne_reg || fs_reg)
            begin
                emit = 1'b1;
                op   = OP_ROW;
            end
            inq_next = 1'b0;
            qp_next  = 1'b0;
            acr_next = 1'b0;
            fs_next  = 1'b0;
            rne_next = 1'b0;
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            acr_next = 1'b0;
            if (acr_reg && in_byte == CH_LF)
                skip = 1'b1;
            if (!skip && qp_reg)
            begin
                qp_next = 1'b0;
                if (in_byte == CH_QUOTE)
                begin
                    cont = 1'b1;
                    skip = 1'b1;
                end
                else
                begin
                    inq_v = 1'b0;
                end
            end
            inq_next = inq_v;
            if (!skip)
            begin
                if (inq_v)
                begin
                    if (in_byte == CH_QUOTE)
                        qp_next = 1'b1;
                    else
                        cont = 1'b1;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    inq_next = 1'b1;
                end
                else if (in_byte == CH_COMMA)
                begin
                    emit     = 1'b1;
                    op       = OP_FIELD;
                    fs_next  = 1'b0;
                    cnt_next = '0;
                    rne_next = 1'b1;
                end
                else if (in_byte inside {CH_CR, CH_LF})
                begin
                    if (rne_reg || fs_reg)
                    begin
                        emit = 1'b1;
                        op   = OP_ROW;
                    end
                    fs_next  = 1'b0;
                    cnt_next = '0;
                    rne_next = 1'b0;
                    acr_next = (in_byte == CH_CR);
                end
                else
                begin
                    cont = 1'b1;
                end
            end

            if (cont)
            begin
                if (in_byte inside {CH_SPACE, CH_TAB})
                begin
                    // blanks before the first real byte are trimmed
                    if (fs_reg)
                    begin
                        if (cnt_reg < CW'(PENDING_MAX))
                        begin
                            emit     = 1'b1;
                            op       = OP_WS;
                            data     = {7'd0, in_byte == CH_TAB};
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    emit     = 1'b1;
                    op       = OP_CHAR;
                    cnt_next = '0;
                    fs_next  = 1'b1;
                end
            end
        end

        push     = accept && emit;
        cmd.op   = op;
        cmd.data = (op == OP_FIELD || op == OP_ROW) ? 8'd0 : data;
        cmd.ovf  = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg <= 1'b0;
            qp_reg  <= 1'b0;
            acr_reg <= 1'b0;
            fs_reg  <= 1'b0;
            rne_reg <= 1'b0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            inq_reg <= inq_next;
            qp_reg  <= qp_next;
            acr_reg <= acr_next;
            fs_reg  <= fs_next;
            rne_reg <= rne_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// ===== rtl/csvfs_queue.sv =====
// ---------------------------------------------------------------------------
// csvfs_queue
// Small command FIFO decoupling the classifier from the result emitter.
// ---------------------------------------------------------------------------
module csvfs_queue
    import csvfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t          store_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] num_reg, num_next;

    assign full       = (num_reg == NW'(DEPTH));
    assign head_valid = (num_reg != '0);
    assign head       = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        num_next    = num_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            num_next = num_reg + 1'b1;
        else if (pop && !push)
            num_next = num_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            num_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            num_reg    <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/csvfs_back.sv =====
// ---------------------------------------------------------------------------
// csvfs_back
// Result emitter: owns the trailing blank buffer, replays parked blanks
// ahead of each real byte, drives the output register.
// ---------------------------------------------------------------------------
module csvfs_back
    import csvfs_pkg::*;
#(
    parameter int PENDING_MAX = PENDING_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last,
    output logic       overflow
);

    localparam int CW = $clog2(PENDING_MAX + 1);
    localparam int AW = $clog2(PENDING_MAX);

    logic          ws_mem [PENDING_MAX];   // 1 tab, 0 space
    logic          rd_data_reg;            // always ws_mem[idx_reg]
    logic          we;
    logic [AW-1:0] raddr;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic          ov_reg, ov_next;
    logic [7:0]    byte_reg, byte_next;
    kind_t         kind_reg, kind_next;
    logic          last_reg, last_next;
    logic          ovf_reg, ovf_next;

    logic          can_load;

    assign can_load = !ov_reg || out_ready;
    assign raddr    = idx_next[AW-1:0];

    always_comb
    begin
        logic load;

        load      = 1'b0;
        pop       = 1'b0;
        we        = 1'b0;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg && !out_ready;
        byte_next = byte_reg;
        kind_next = kind_reg;
        last_next = last_reg;
        ovf_next  = ovf_reg;

        if (head_valid)
        begin
            case (head.op)
                OP_WS:
                begin
                    we       = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    pop      = 1'b1;
                end
                OP_CHAR:
                begin
                    if (can_load)
                    begin
                        load = 1'b1;
                        kind_next = KIND_BYTE;
                        if (idx_reg < cnt_reg)
                        begin
                            byte_next = rd_data_reg ? CH_TAB : CH_SPACE;
                            last_next = 1'b0;
                            idx_next  = idx_reg + 1'b1;
                        end
                        else
                        begin
                            byte_next = head.data;
                            last_next = 1'b1;
                            pop       = 1'b1;
                            cnt_next  = '0;
                            idx_next  = '0;
                        end
                    end
                end
                OP_FIELD, OP_ROW:
                begin
                    if (can_load)
                    begin
                        load      = 1'b1;
                        byte_next = 8'd0;
                        kind_next = (head.op == OP_FIELD) ? KIND_FIELD : KIND_ROW;
                        last_next = 1'b1;
                        pop       = 1'b1;
                        cnt_next  = '0;
                        idx_next  = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (load)
        begin
            ov_next  = 1'b1;
            ovf_next = head.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    // blank buffer, write-through on a same-address read
    always_ff @(posedge clk)
    begin
        if (we)
            ws_mem[cnt_reg[AW-1:0]] <= head.data[0];
        if (we && cnt_reg[AW-1:0] == raddr)
            rd_data_reg <= head.data[0];
        else
            rd_data_reg <= ws_mem[raddr];
    end

    assign out_valid = ov_reg;
    assign out_byte  = byte_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;
    assign overflow  = ovf_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(PENDING_MAX))
        else $error("blank count beyond buffer");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("replay index past blank count");

    a_ws_room: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head.op == OP_WS |-> cnt_reg < CW'(PENDING_MAX))
        else $error("blank parked into a full buffer");

    a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && kind_reg != KIND_BYTE |-> last_reg)
        else $error("mark beat not flagged last");

endmodule

// ===== rtl/csv_field_splitter.sv =====
// ---------------------------------------------------------------------------
// csv_field_splitter
// Streaming CSV splitter: bytes in, content bytes and field/row marks out.
// ---------------------------------------------------------------------------
// One input beat is taken per cycle while the command queue has room. Each
// beat becomes at most one command; most commands leave as one output beat.
// A real byte that follows N parked trailing blanks makes N+1 output beats,
// one per cycle while the output is ready, as the emitter replays its blank
// buffer; the queue (QUEUE_DEPTH commands) absorbs the input side meanwhile,
// so the sustained rate is one beat per cycle except during such replays and
// output stalls. Blanks past PENDING_MAX in one run are dropped and set the
// sticky overflow bit carried on every later beat until an end-of-input
// beat, which closes the last row (open quotes closed silently, parked
// blanks dropped) and clears all state. A row holding one empty field makes
// no output. The blank buffer has no reset and needs no clearing pass.
// ---------------------------------------------------------------------------
module csv_field_splitter
    import csvfs_pkg::*;
#(
    parameter int PENDING_MAX = PENDING_MAX_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] kind,
    output logic       last,
    output logic       overflow
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_full;
    logic head_valid;
    cmd_t head;

    // front takes a beat whenever the queue can hold its command
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    csvfs_front #(
        .PENDING_MAX (PENDING_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .push         (push),
        .cmd          (push_cmd)
    );

    csvfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    csvfs_back #(
        .PENDING_MAX (PENDING_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind),
        .last       (last),
        .overflow   (overflow)
    );

endmodule
